// File: rtl/rc4t_pkg.sv
// Shared constants, types and codes for the tiny RC4 stream cipher unit.
package rc4t_pkg;

    // Permutation table geometry (power of two).
    localparam int TABLE_SIZE = 8;
    localparam int IDX_W      = $clog2(TABLE_SIZE);

    // Field and register widths.
    localparam int KEY_W      = 3;
    localparam int VAL_W      = 3;
    localparam int KEY_COUNT  = 3;
    localparam int KIDX_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 8;

    typedef logic [IDX_W-1:0] idx_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0 = 2'd0,
        CFG_KEY1 = 2'd1,
        CFG_KEY2 = 2'd2
    } cfg_reg_t;

    // Operations of the shared index adder.
    typedef enum logic [1:0] {
        ALU_SCHED,
        ALU_INC_I,
        ALU_STEP_J,
        ALU_SUM
    } alu_op_t;

    // Operand bundle offered to the shared adder.
    typedef struct packed {
        idx_t acc;
        idx_t key;
        idx_t rd_val;
        idx_t idx_i;
        idx_t idx_j;
        idx_t s_i;
        idx_t s_j;
    } alu_opnd_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCH_RD_N,
        ST_SCH_RD_A,
        ST_SCH_WR_N,
        ST_SCH_WR_A,
        ST_GEN_RD_I,
        ST_GEN_RD_J,
        ST_GEN_WR_I,
        ST_GEN_WR_J,
        ST_GEN_RD_T,
        ST_GEN_KS,
        ST_DONE
    } state_t;

endpackage

// File: rtl/rc4t_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rc4t_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/rc4t_alu.sv
// Shared index adder: selects operands by operation and adds modulo the table size.
module rc4t_alu (
    input  rc4t_pkg::alu_op_t   op,
    input  rc4t_pkg::alu_opnd_t opnd,
    output rc4t_pkg::idx_t      sum
);
    import rc4t_pkg::*;

    idx_t op_a;
    idx_t op_b;
    idx_t op_c;

    // Operand selection for each use of the adder.
    always_comb begin
        op_a = '0;
        op_b = '0;
        op_c = '0;
        case (op)
            ALU_SCHED: begin
                op_a = opnd.acc;
                op_b = opnd.rd_val;
                op_c = opnd.key;
            end
            ALU_INC_I: begin
                op_a = opnd.idx_i;
                op_b = IDX_W'(1);
            end
            ALU_STEP_J: begin
                op_a = opnd.idx_j;
                op_b = opnd.rd_val;
            end
            ALU_SUM: begin
                op_a = opnd.s_i;
                op_b = opnd.s_j;
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    // Wrapping add gives the result modulo the table size.
    assign sum = op_a + op_b + op_c;

endmodule

// File: rtl/tiny_rc4_stream_cipher_unit.sv
// Tiny RC4 stream cipher unit: an 8-entry permutation of 3-bit words with a 3-word key.
// Each input beat produces one output beat carrying the keystream word and its XOR with the
// input word. The permutation lives in a table RAM with one write and one read port that one
// sequencer walks with one shared adder, and the input stays not ready until a result has been
// placed in the output register. A beat with restart set, and the first beat after reset, first
// runs the key schedule: 8 swaps, each reading S[n] and S[a] and then writing both back. Key
// registers may be written while idle; a new key is used from the next restart. The output
// register lets a new beat enter while a result still waits.
module tiny_rc4_stream_cipher_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: restart [0], plain_value [3:1], zero fill [7:4]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rc4t_pkg::S_TDATA_W-1:0]      s_tdata,
    // m_tdata: keystream_value [2:0], cipher_value [5:3], zero fill [7:6]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rc4t_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [rc4t_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rc4t_pkg::KEY_W-1:0]          cfg_wr_data
);
    import rc4t_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [KEY_W-1:0]  key0_reg;
    logic [KEY_W-1:0]  key1_reg;
    logic [KEY_W-1:0]  key2_reg;
    logic              keyed_reg;
    logic [VAL_W-1:0]  plain_reg;
    idx_t              i_reg;
    idx_t              j_reg;
    idx_t              n_reg;
    idx_t              acc_reg;
    idx_t              si_reg;
    idx_t              sj_reg;
    idx_t              t_reg;
    idx_t              ks_reg;
    logic [KIDX_W-1:0] kidx_reg;
    logic [TABLE_SIZE-1:0] valid_reg;
    logic              rd_hit_reg;
    idx_t              rd_addr_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic       in_accept;
    logic       need_sched;
    logic       out_free;
    logic       ram_we;
    idx_t       ram_waddr;
    idx_t       ram_wdata;
    idx_t       ram_raddr;
    idx_t       ram_rdata;
    idx_t       rd_val;
    idx_t       key_sel;
    idx_t       alu_sum;
    alu_op_t    alu_op;
    alu_opnd_t  alu_opnd;
    logic [VAL_W-1:0] ks_val;

    assign s_tready   = (state_reg == ST_IDLE) && aresetn;
    assign in_accept  = s_tvalid && s_tready;
    assign need_sched = s_tdata[0] || !keyed_reg;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    // Table storage.
    rc4t_ram #(
        .WIDTH (IDX_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // An entry never written since the last identity load reads as its own index.
    assign rd_val = rd_hit_reg ? ram_rdata : rd_addr_reg;

    // Key word for the current schedule position.
    always_comb begin
        case (kidx_reg)
            2'd0:    key_sel = IDX_W'(key0_reg);
            2'd1:    key_sel = IDX_W'(key1_reg);
            2'd2:    key_sel = IDX_W'(key2_reg);
            default: key_sel = IDX_W'(key0_reg);
        endcase
    end

    assign alu_opnd = '{acc: acc_reg, key: key_sel, rd_val: rd_val, idx_i: i_reg,
                        idx_j: j_reg, s_i: si_reg, s_j: sj_reg};

    rc4t_alu u_alu (
        .op   (alu_op),
        .opnd (alu_opnd),
        .sum  (alu_sum)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = need_sched ? ST_SCH_RD_N : ST_GEN_RD_I;
                end
            end
            ST_SCH_RD_N: state_next = ST_SCH_RD_A;
            ST_SCH_RD_A: state_next = ST_SCH_WR_N;
            ST_SCH_WR_N: state_next = ST_SCH_WR_A;
            ST_SCH_WR_A: begin
                state_next = (n_reg == IDX_W'(TABLE_SIZE - 1)) ? ST_GEN_RD_I : ST_SCH_RD_N;
            end
            ST_GEN_RD_I: state_next = ST_GEN_RD_J;
            ST_GEN_RD_J: state_next = ST_GEN_WR_I;
            ST_GEN_WR_I: state_next = ST_GEN_WR_J;
            ST_GEN_WR_J: state_next = ST_GEN_RD_T;
            ST_GEN_RD_T: state_next = ST_GEN_KS;
            ST_GEN_KS:   state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Table port and adder controls for each state.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        alu_op    = ALU_SUM;
        case (state_reg)
            ST_SCH_RD_N: ram_raddr = n_reg;
            ST_SCH_RD_A: begin
                alu_op    = ALU_SCHED;
                ram_raddr = alu_sum;
            end
            ST_SCH_WR_N: begin
                ram_we    = 1'b1;
                ram_waddr = n_reg;
                ram_wdata = rd_val;
            end
            ST_SCH_WR_A: begin
                ram_we    = 1'b1;
                ram_waddr = acc_reg;
                ram_wdata = si_reg;
            end
            ST_GEN_RD_I: begin
                alu_op    = ALU_INC_I;
                ram_raddr = alu_sum;
            end
            ST_GEN_RD_J: begin
                alu_op    = ALU_STEP_J;
                ram_raddr = alu_sum;
            end
            ST_GEN_WR_I: begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = rd_val;
            end
            ST_GEN_WR_J: begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
                alu_op    = ALU_SUM;
            end
            ST_GEN_RD_T: ram_raddr = t_reg;
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // State, key registers, entry valid bits and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            keyed_reg    <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_KEY0: key0_reg <= cfg_wr_data;
                    CFG_KEY1: key1_reg <= cfg_wr_data;
                    CFG_KEY2: key2_reg <= cfg_wr_data;
                    default:  key0_reg <= key0_reg;
                endcase
            end

            // Schedule start reloads the identity permutation at once.
            if (state_reg == ST_IDLE && in_accept && need_sched) begin
                valid_reg <= '0;
            end else if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end

            if (state_reg == ST_SCH_WR_A && n_reg == IDX_W'(TABLE_SIZE - 1)) begin
                keyed_reg <= 1'b1;
                i_reg     <= '0;
                j_reg     <= '0;
            end
            if (state_reg == ST_GEN_RD_I) begin
                i_reg <= alu_sum;
            end
            if (state_reg == ST_GEN_RD_J) begin
                j_reg <= alu_sum;
            end

            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign ks_val = VAL_W'(ks_reg);

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        rd_hit_reg  <= valid_reg[ram_raddr];
        rd_addr_reg <= ram_raddr;

        if (state_reg == ST_IDLE && in_accept) begin
            plain_reg <= s_tdata[VAL_W:1];
            n_reg     <= '0;
            acc_reg   <= '0;
            kidx_reg  <= '0;
        end
        if (state_reg == ST_SCH_RD_A) begin
            acc_reg <= alu_sum;
            si_reg  <= rd_val;
        end
        if (state_reg == ST_SCH_WR_A) begin
            n_reg    <= n_reg + IDX_W'(1);
            kidx_reg <= (kidx_reg == KIDX_W'(KEY_COUNT - 1)) ? '0 : kidx_reg + KIDX_W'(1);
        end
        if (state_reg == ST_GEN_RD_J) begin
            si_reg <= rd_val;
        end
        if (state_reg == ST_GEN_WR_I) begin
            sj_reg <= rd_val;
        end
        if (state_reg == ST_GEN_WR_J) begin
            t_reg <= alu_sum;
        end
        if (state_reg == ST_GEN_KS) begin
            ks_reg <= rd_val;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {2'b00, plain_reg ^ ks_val, ks_val};
        end
    end

endmodule

// File: rtl/rc4t_checker.sv
// Port-level checker for the tiny RC4 stream cipher unit, bound to the top level.
module rc4t_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A beat occupies the sequencer, so ready drops right after acceptance.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready stayed high after an accepted beat");

    // A result must not rise too soon after an acceptance; one later sample is checked.
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> ##2 !$rose(m_tvalid))
        else $error("result appeared too soon after an accepted beat");

    // Fill bits of the result are zero.
    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:6] == 2'b00))
        else $error("result fill bits not zero");

    // A stalled result holds its data.
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or vanished");

endmodule

bind tiny_rc4_stream_cipher_unit rc4t_checker u_rc4t_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
